FILE: rtl/core/merge_sort_assert.svh
// merge_sort_assert.svh: assertion macros used by the merge sort checker.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef MERGE_SORT_ASSERT_SVH
`define MERGE_SORT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define MS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("merge_sort: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset
`define MS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("merge_sort: next-cycle check failed");

`endif

FILE: rtl/core/ms_pkg.sv
// ms_pkg: types and constants of the merge sort block.
// No dependencies; imported by the interfaces, the sequencer and the top level.
package ms_pkg;

	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] ms_word_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PRIME,
		ST_MERGE,
		ST_OUT_PRIME,
		ST_OUT
	} ms_state_t;

	// Memory control from the sequencer to the two stores
	typedef struct packed {
		logic we_store;  // write element store
		logic we_buf;    // write merge buffer
		logic re;        // read enable, both stores
		logic rd_sel;    // 0: element store is the source, 1: merge buffer
	} ms_mem_ctl_t;

endpackage

FILE: rtl/core/ms_if.sv
// ms_if: valid/ready channels for the merge sort input and result streams.
// Depends on ms_pkg for the word type.
interface ms_in_if;
	import ms_pkg::*;

	logic     valid;
	logic     ready;
	ms_word_t sample_value;
	logic     end_of_set;

	modport source(output valid, output sample_value, output end_of_set, input ready);
	modport sink(input valid, input sample_value, input end_of_set, output ready);
endinterface

interface ms_out_if;
	import ms_pkg::*;

	logic     valid;
	logic     ready;
	ms_word_t sorted_value;
	logic     final_item;

	modport source(output valid, output sorted_value, output final_item, input ready);
	modport sink(input valid, input sorted_value, input final_item, output ready);
endinterface

FILE: rtl/core/merge_sort.sv
// Merge sort: collects up to MAX_ELEMS signed words, sorts them ascending (stable) by
// bottom-up merging between two single-write, dual-read stores, then streams them out.
// Load: accepted elements are written to the element store. Sort: ceil(log2 n) passes,
// one merged element per cycle, bounded by the store write port. Drain: one result per
// cycle while the receiver is ready.
// Reset clears the sequencer and set size only; the store contents are left as they are.
module merge_sort #(
	parameter int MAX_ELEMS = 64
) (
	input logic            clk,
	input logic            arst_n,
	ms_in_if.sink          elems,
	ms_out_if.source       result
);
	import ms_pkg::*;

	localparam int AW = $clog2(MAX_ELEMS);

	ms_mem_ctl_t ctl;
	logic [AW-1:0] waddr, raddr_a, raddr_b;
	ms_word_t wdata, rd_a, rd_b;
	logic [WORD_W-1:0] store_rd0, store_rd1, buf_rd0, buf_rd1;

	// Sequencer
	ms_seq #(
		.MAX_ELEMS(MAX_ELEMS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (elems.valid),
		.in_ready    (elems.ready),
		.sample_value(elems.sample_value),
		.end_of_set  (elems.end_of_set),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.final_item  (result.final_item),
		.rd_a        (rd_a),
		.rd_b        (rd_b),
		.ctl         (ctl),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr_a     (raddr_a),
		.raddr_b     (raddr_b)
	);

	// Element store: loaded elements and even-pass results
	ms_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_ELEMS)
	) u_store (
		.clk   (clk),
		.we    (ctl.we_store),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.re),
		.raddr0(raddr_a),
		.raddr1(raddr_b),
		.rdata0(store_rd0),
		.rdata1(store_rd1)
	);

	// Merge buffer: odd-pass results
	ms_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_ELEMS)
	) u_buf (
		.clk   (clk),
		.we    (ctl.we_buf),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.re),
		.raddr0(raddr_a),
		.raddr1(raddr_b),
		.rdata0(buf_rd0),
		.rdata1(buf_rd1)
	);

	// Select the source store; its read register also holds the result
	assign rd_a = ctl.rd_sel ? ms_word_t'(buf_rd0) : ms_word_t'(store_rd0);
	assign rd_b = ctl.rd_sel ? ms_word_t'(buf_rd1) : ms_word_t'(store_rd1);
	assign result.sorted_value = rd_a;

endmodule

FILE: rtl/core/ms_ram.sv
// ms_ram: generic synchronous RAM, one write port, two registered read ports.
// No dependencies; read data holds while the read enable is low.
module ms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

FILE: rtl/core/ms_seq.sv
// ms_seq: load, bottom-up merge pass and drain sequencer of the merge sort.
// Depends on ms_pkg; drives the two stores instantiated in merge_sort.
module ms_seq #(
	parameter int MAX_ELEMS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ms_pkg::ms_word_t             sample_value,
	input  logic                         end_of_set,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         final_item,
	input  ms_pkg::ms_word_t             rd_a,
	input  ms_pkg::ms_word_t             rd_b,
	output ms_pkg::ms_mem_ctl_t          ctl,
	output logic [$clog2(MAX_ELEMS)-1:0] waddr,
	output ms_pkg::ms_word_t             wdata,
	output logic [$clog2(MAX_ELEMS)-1:0] raddr_a,
	output logic [$clog2(MAX_ELEMS)-1:0] raddr_b
);
	import ms_pkg::*;

	localparam int AW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam int SW = CW + 1;

	ms_state_t     state_q, state_d;
	logic [CW-1:0] count_q;   // elements in the set
	logic [CW-1:0] w_q;       // run width of the current pass
	logic [CW-1:0] a_q, b_q;  // heads of the two runs
	logic [CW-1:0] mid_q, hi_q;
	logic [CW-1:0] k_q;       // merge write index, drain read index
	logic          src_q;     // store holding the current runs

	logic          in_fire, out_fire, set_end;
	logic          a_ok, b_ok, take_a, seg_last, pass_end, sort_done;
	logic [SW-1:0] hi_w, hi_2w, w2, n_ext;
	logic [CW-1:0] mid_n, hi_n, prime_hi, a_nxt, b_nxt, k_inc;

	// Handshakes and set end
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign set_end  = end_of_set || (count_q == CW'(MAX_ELEMS - 1));

	// Merge decision: earlier run wins ties
	assign a_ok   = a_q < mid_q;
	assign b_ok   = b_q < hi_q;
	assign take_a = a_ok && (!b_ok || (rd_a <= rd_b));

	// Bounds of the next merge segment, clamped to the set size
	assign n_ext    = {1'b0, count_q};
	assign hi_w     = {1'b0, hi_q} + {1'b0, w_q};
	assign hi_2w    = hi_w + {1'b0, w_q};
	assign w2       = {w_q, 1'b0};
	assign mid_n    = (hi_w >= n_ext) ? count_q : hi_w[CW-1:0];
	assign hi_n     = (hi_2w >= n_ext) ? count_q : hi_2w[CW-1:0];
	assign prime_hi = (w2 >= n_ext) ? count_q : w2[CW-1:0];
	assign k_inc    = k_q + CW'(1);
	assign seg_last = (k_inc == hi_q);
	assign pass_end = seg_last && (hi_q == count_q);
	assign sort_done = (w2 >= n_ext);

	// Next read heads during a merge
	always_comb begin
		a_nxt = take_a ? a_q + CW'(1) : a_q;
		b_nxt = take_a ? b_q : b_q + CW'(1);
		if (seg_last) begin
			a_nxt = hi_q;
			b_nxt = mid_n;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_fire && set_end) begin
					state_d = (count_q == '0) ? ST_OUT_PRIME : ST_PRIME;
				end
			end
			ST_PRIME:     state_d = ST_MERGE;
			ST_MERGE: begin
				if (pass_end) begin
					state_d = sort_done ? ST_OUT_PRIME : ST_PRIME;
				end
			end
			ST_OUT_PRIME: state_d = ST_OUT;
			ST_OUT: begin
				if (out_fire && final_item) begin
					state_d = ST_LOAD;
				end
			end
			default:      state_d = ST_LOAD;
		endcase
	end

	// Outputs: handshake and memory control
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		final_item = 1'b0;
		ctl        = '0;
		ctl.rd_sel = src_q;
		waddr      = k_q[AW-1:0];
		wdata      = take_a ? rd_a : rd_b;
		raddr_a    = '0;
		raddr_b    = '0;
		case (state_q)
			ST_LOAD: begin
				in_ready     = 1'b1;
				ctl.we_store = in_fire;
				waddr        = count_q[AW-1:0];
				wdata        = sample_value;
			end
			ST_PRIME: begin
				ctl.re  = 1'b1;
				raddr_b = w_q[AW-1:0];
			end
			ST_MERGE: begin
				ctl.re       = 1'b1;
				ctl.we_store = src_q;
				ctl.we_buf   = !src_q;
				raddr_a      = a_nxt[AW-1:0];
				raddr_b      = b_nxt[AW-1:0];
			end
			ST_OUT_PRIME: begin
				ctl.re = 1'b1;
			end
			ST_OUT: begin
				out_valid  = 1'b1;
				final_item = (k_inc == count_q);
				ctl.re     = out_ready;
				raddr_a    = k_inc[AW-1:0];
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Set size, pass width and store selection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			w_q     <= '0;
			src_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						count_q <= count_q + CW'(1);
						w_q     <= CW'(1);
						src_q   <= 1'b0;
					end
				end
				ST_MERGE: begin
					if (pass_end) begin
						w_q   <= w2[CW-1:0];
						src_q <= !src_q;
					end
				end
				ST_OUT: begin
					if (out_fire && final_item) begin
						count_q <= '0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Run heads, bounds and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q   <= '0;
			b_q   <= '0;
			mid_q <= '0;
			hi_q  <= '0;
			k_q   <= '0;
		end else begin
			case (state_q)
				ST_PRIME: begin
					a_q   <= '0;
					b_q   <= w_q;
					mid_q <= w_q;
					hi_q  <= prime_hi;
					k_q   <= '0;
				end
				ST_MERGE: begin
					k_q <= k_inc;
					a_q <= a_nxt;
					b_q <= b_nxt;
					if (seg_last) begin
						mid_q <= mid_n;
						hi_q  <= hi_n;
					end
				end
				ST_OUT_PRIME: begin
					k_q <= '0;
				end
				ST_OUT: begin
					if (out_fire) begin
						k_q <= k_inc;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/merge_sort_chk.sv
// merge_sort_chk: port-level checks of the merge sort, bound to the top level.
// Depends on merge_sort_assert.svh for the assertion macros.
`include "merge_sort_assert.svh"

module merge_sort_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_end,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_value,
	input logic               out_final
);

	// No request taken while results are pending
	`MS_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
	// Intake stops once a request with the set end is taken
	`MS_ASSERT_NEXT(a_end_blocks, in_valid && in_ready && in_end, !in_ready)
	// Drain stops after the final result
	`MS_ASSERT_NEXT(a_final_stops, out_valid && out_ready && out_final, !out_valid)
	// Results rise monotonically within a set
	`MS_ASSERT_NOW(a_ascending, out_valid && $past(out_valid && out_ready && !out_final), $signed(out_value) >= $signed($past(out_value)))
	// A stalled result holds
	`MS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_value))

endmodule

bind merge_sort merge_sort_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (elems.valid),
	.in_ready (elems.ready),
	.in_end   (elems.end_of_set),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_value(result.sorted_value),
	.out_final(result.final_item)
);

FILE: bench/merge_sort_test.sv
// merge_sort_test: self-checking bench for the merge sort block, fed with sets of signed words.
// Needs ms_pkg, the ms_in_if/ms_out_if channels and the merge_sort top level with its sequencer and stores.
// Predicts each sorted set on its closing request and checks every result in order.
module merge_sort_test;
	import ms_pkg::*;

	localparam int SET_LIMIT = 64;
	localparam ms_word_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam ms_word_t WORD_MIN = 32'sh8000_0000;

	typedef ms_word_t word_q_t[$];

	typedef struct {
		ms_word_t value;
		logic     last;
	} sample_req_t;

	typedef struct {
		ms_word_t value;
		logic     final_mark;
	} sorted_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// locally held drive values, known from time zero
	logic     in_valid = 1'b0;
	ms_word_t in_value = '0;
	logic     in_last = 1'b0;
	logic     out_ready = 1'b0;

	ms_in_if  elems_ch ();
	ms_out_if result_ch ();

	assign elems_ch.valid        = in_valid;
	assign elems_ch.sample_value = in_value;
	assign elems_ch.end_of_set   = in_last;
	assign result_ch.ready       = out_ready;

	merge_sort #(.MAX_ELEMS(SET_LIMIT)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.elems  (elems_ch),
		.result (result_ch)
	);

	sample_req_t    pending_reqs[$];
	sorted_result_t expected_sorted[$];
	ms_word_t       open_set[$];

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int reqs_sent = 0;
	int results_seen = 0;
	int sets_closed = 0;
	int full_sets = 0;

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Guard against a hung run
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Stable ascending sort of a copy of the set
	function automatic word_q_t sort_ascending(input word_q_t vals);
		int       j;
		ms_word_t key;
		for (int i = 1; i < vals.size(); i++) begin
			key = vals[i];
			j = i;
			while (j > 0 && vals[j-1] > key) begin
				vals[j] = vals[j-1];
				j--;
			end
			vals[j] = key;
		end
		return vals;
	endfunction

	// Add an accepted request to the open set; close it on the end mark or a full store
	task automatic predict_sorted(input ms_word_t value, input logic last);
		word_q_t        ordered;
		sorted_result_t res;
		open_set.push_back(value);
		if (last || open_set.size() == SET_LIMIT) begin
			if (open_set.size() == SET_LIMIT)
				full_sets++;
			ordered = sort_ascending(open_set);
			foreach (ordered[k]) begin
				res.value = ordered[k];
				res.final_mark = (k == ordered.size() - 1);
				expected_sorted.push_back(res);
			end
			open_set.delete();
			sets_closed++;
		end
	endtask

	// Queue a set of requests, with the end mark on the last one unless told otherwise
	task automatic queue_set(input word_q_t vals, input logic mark_end);
		sample_req_t req;
		foreach (vals[k]) begin
			req.value = vals[k];
			req.last = (k == vals.size() - 1) ? mark_end : 1'b0;
			pending_reqs.push_back(req);
		end
	endtask

	// Mix of near-zero values (for ties), extremes and full-range words
	function automatic ms_word_t random_word();
		case ($urandom_range(3))
			0: return ms_word_t'($urandom_range(8)) - 4;
			1: begin
				case ($urandom_range(3))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					default: return -1;
				endcase
			end
			default: return ms_word_t'($urandom);
		endcase
	endfunction

	task automatic queue_random_sets(input int min_reqs);
		word_q_t vals;
		int      added;
		int      n;
		added = 0;
		while (added < min_reqs) begin
			n = $urandom_range(10, 1);
			vals.delete();
			repeat (n) vals.push_back(random_word());
			queue_set(vals, 1'b1);
			added += n;
		end
	endtask

	// Driver: present requests from the pending queue, idling at the current rate
	always @(posedge clk or negedge arst_n) begin : drive_requests
		sample_req_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && elems_ch.ready) begin
				predict_sorted(in_value, in_last);
				reqs_sent++;
			end
			if (!in_valid || elems_ch.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					in_value <= next_req.value;
					in_last  <= next_req.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_results
		sorted_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (result_ch.valid && out_ready) begin
				results_seen++;
				if (expected_sorted.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d", result_ch.sorted_value));
				end else begin
					want = expected_sorted.pop_front();
					if (result_ch.sorted_value !== want.value)
						report_mismatch($sformatf("sorted_value %0d, want %0d",
							result_ch.sorted_value, want.value));
					if (result_ch.final_item !== want.final_mark)
						report_mismatch($sformatf("final_item %b, want %b",
							result_ch.final_item, want.final_mark));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus: directed sets, then random sets under four idling patterns
	initial begin : run_phases
		word_q_t vals;
		word_q_t full_set;
		int      send_pct[4];
		int      stall_pct[4];
		send_pct  = '{0, 73, 0, 15};
		stall_pct = '{0, 0, 73, 15};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Single-element sets at both extremes
		vals = '{WORD_MAX};
		queue_set(vals, 1'b1);
		vals = '{WORD_MIN};
		queue_set(vals, 1'b1);
		// Extremes and the values around zero together
		vals = '{WORD_MAX, WORD_MIN, 0, -1, 1};
		queue_set(vals, 1'b1);
		// Repeated values
		vals = '{7, 7, -3, 7, -3};
		queue_set(vals, 1'b1);
		// Alternating bit patterns
		vals = '{32'sh5555_5555, 32'shAAAA_AAAA, -2, 2};
		queue_set(vals, 1'b1);
		// Pairs already in order and reversed
		vals = '{-5, 5};
		queue_set(vals, 1'b1);
		vals = '{5, -5};
		queue_set(vals, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = send_pct[ph];
			recv_stall_pct = stall_pct[ph];
			// A set that fills the store, end mark on the filling request left to chance
			if (ph == 2) begin
				full_set.delete();
				repeat (SET_LIMIT) full_set.push_back(random_word());
				queue_set(full_set, 1'(($urandom_range(1))));
			end
			queue_random_sets(8);
			// Hold off new requests until every sorted result of the phase is in
			while (pending_reqs.size() > 0 || in_valid || expected_sorted.size() > 0)
				@(negedge clk);
		end

		// Let any stray result show itself
		repeat (60) @(posedge clk);

		$display("Covered %0d requests in %0d sets (%0d filled the store), %0d results checked,",
			reqs_sent, sets_closed, full_sets, results_seen);
		$display("with free-running, idle-sender, stalled-receiver and mixed-idle phases.");
		if (error_count == 0 && expected_sorted.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
